// ===== hw/rtl/morse_code_translator_core_defines.svh =====
// ----------------------------------------------------------------------------
// Morse translator assertion macros
// Shared helpers for the concurrent checks in the translator RTL.
// ----------------------------------------------------------------------------
`ifndef MORSE_CODE_TRANSLATOR_CORE_DEFINES_SVH
`define MORSE_CODE_TRANSLATOR_CORE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define MCT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition in one cycle that implies another in the next cycle.
`define MCT_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== hw/rtl/mct_pkg.sv =====
// ----------------------------------------------------------------------------
// Morse translator package
// Payload types, character codes and the ITU code table.
// ----------------------------------------------------------------------------
package mct_pkg;

	localparam int TABLE_SIZE = 36;
	localparam int LETTERS    = 26;
	localparam int JOB_SYMS   = 5;

	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_DASH  = 8'd45;
	localparam logic [7:0] CH_DOT   = 8'd46;
	localparam logic [7:0] CH_SLASH = 8'd47;
	localparam logic [7:0] CH_QUEST = 8'd63;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_UC_A  = 8'd65;
	localparam logic [7:0] CH_UC_Z  = 8'd90;
	localparam logic [7:0] CH_LC_A  = 8'd97;
	localparam logic [7:0] CH_LC_Z  = 8'd122;
	localparam logic [7:0] CASE_GAP = 8'd32;

	typedef struct packed {
		logic [7:0] in_char;
		logic       end_of_text;
	} mct_in_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       run_last;
		logic       bad_code;
	} mct_out_t;

	// One unit of work for the back end: a run of symbols, then an optional
	// character, then an optional space.
	typedef struct packed {
		logic [2:0]          len;
		logic [JOB_SYMS-1:0] bits;
		logic                a_en;
		logic [7:0]          a_char;
		logic                a_bad;
		logic                b_en;
	} mct_job_t;

	// Table entry: length in bits 8..6, symbols in bits 5..0, first at bit 0,
	// dash is one.
	function automatic logic [8:0] mct_code(input logic [5:0] idx);
		logic [8:0] e;
		case (idx)
			6'd0:  e = {3'd2, 6'd2};
			6'd1:  e = {3'd4, 6'd1};
			6'd2:  e = {3'd4, 6'd5};
			6'd3:  e = {3'd3, 6'd1};
			6'd4:  e = {3'd1, 6'd0};
			6'd5:  e = {3'd4, 6'd4};
			6'd6:  e = {3'd3, 6'd3};
			6'd7:  e = {3'd4, 6'd0};
			6'd8:  e = {3'd2, 6'd0};
			6'd9:  e = {3'd4, 6'd14};
			6'd10: e = {3'd3, 6'd5};
			6'd11: e = {3'd4, 6'd2};
			6'd12: e = {3'd2, 6'd3};
			6'd13: e = {3'd2, 6'd1};
			6'd14: e = {3'd3, 6'd7};
			6'd15: e = {3'd4, 6'd6};
			6'd16: e = {3'd4, 6'd11};
			6'd17: e = {3'd3, 6'd2};
			6'd18: e = {3'd3, 6'd0};
			6'd19: e = {3'd1, 6'd1};
			6'd20: e = {3'd3, 6'd4};
			6'd21: e = {3'd4, 6'd8};
			6'd22: e = {3'd3, 6'd6};
			6'd23: e = {3'd4, 6'd9};
			6'd24: e = {3'd4, 6'd13};
			6'd25: e = {3'd4, 6'd3};
			6'd26: e = {3'd5, 6'd31};
			6'd27: e = {3'd5, 6'd30};
			6'd28: e = {3'd5, 6'd28};
			6'd29: e = {3'd5, 6'd24};
			6'd30: e = {3'd5, 6'd16};
			6'd31: e = {3'd5, 6'd0};
			6'd32: e = {3'd5, 6'd1};
			6'd33: e = {3'd5, 6'd3};
			6'd34: e = {3'd5, 6'd7};
			6'd35: e = {3'd5, 6'd15};
			default: e = 9'd0;
		endcase
		return e;
	endfunction

	// Character of a table index: letters first, then digits.
	function automatic logic [7:0] mct_index_char(input logic [5:0] idx);
		logic [7:0] ch;
		if (idx < 6'(LETTERS)) begin
			ch = CH_UC_A + 8'(idx);
		end else begin
			ch = CH_ZERO + 8'(idx - 6'(LETTERS));
		end
		return ch;
	endfunction

endpackage

// ===== hw/rtl/mct_front.sv =====
// ----------------------------------------------------------------------------
// Morse translator front end
// Accepts text bytes, holds the direction and the gathered code, and turns
// each byte into a job for the back end.
// ----------------------------------------------------------------------------
module mct_front import mct_pkg::*; #(
	parameter int MAX_SYMBOLS = 6
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_wr_en,
	input  logic     cfg_wr_data,
	input  logic     in_valid,
	output logic     in_ready,
	input  mct_in_t  in_data,
	input  logic     queue_full,
	output logic     job_push,
	output mct_job_t job
);

	localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
	localparam int IDX_W = $clog2(MAX_SYMBOLS);

	logic                   dir_q;
	logic [MAX_SYMBOLS-1:0] sym_bits_q;
	logic [CNT_W-1:0]       sym_cnt_q;
	logic                   ovf_q;

	logic                   accept;
	logic [7:0]             c;
	logic [7:0]             uc;
	logic                   is_letter, is_digit, do_lookup, match_any;
	logic [5:0]             enc_idx;
	logic [8:0]             enc_entry;
	logic [8:0]             tab_entry;
	logic [7:0]             dec_char;
	logic [MAX_SYMBOLS-1:0] g_bits;
	logic [CNT_W-1:0]       g_cnt;
	logic                   g_ovf;
	logic                   good;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign c        = in_data.in_char;

	always_comb begin
		// Symbol gathering for the decode direction.
		g_bits = sym_bits_q;
		g_cnt  = sym_cnt_q;
		g_ovf  = ovf_q;
		if (c == CH_DOT || c == CH_DASH) begin
			if (g_cnt < CNT_W'(MAX_SYMBOLS)) begin
				if (c == CH_DASH) begin
					g_bits[g_cnt[IDX_W-1:0]] = 1'b1;
				end
				g_cnt = g_cnt + CNT_W'(1);
			end else begin
				g_ovf = 1'b1;
			end
		end
		do_lookup = (c == CH_SPACE) || in_data.end_of_text;

		// Codes in the table are unique, so the matches can simply be ORed.
		match_any = 1'b0;
		dec_char  = 8'd0;
		tab_entry = 9'd0;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			tab_entry = mct_code(6'(i));
			if (CNT_W'(tab_entry[8:6]) == g_cnt &&
			    MAX_SYMBOLS'(tab_entry[5:0]) == g_bits) begin
				match_any = 1'b1;
				dec_char  = dec_char | mct_index_char(6'(i));
			end
		end
		good = match_any && !g_ovf;

		// Encode direction classification.
		uc = (c >= CH_LC_A && c <= CH_LC_Z) ? c - CASE_GAP : c;
		is_letter = (uc >= CH_UC_A) && (uc <= CH_UC_Z);
		is_digit  = (uc >= CH_ZERO) && (uc <= CH_NINE);
		enc_idx   = is_letter ? 6'(uc - CH_UC_A) : 6'(uc - CH_ZERO) + 6'(LETTERS);
		enc_entry = mct_code(enc_idx);

		job = '0;
		if (dir_q) begin
			job.a_en   = do_lookup && (g_ovf || g_cnt != '0);
			job.a_char = good ? dec_char : CH_QUEST;
			job.a_bad  = !good;
			job.b_en   = (c == CH_SLASH);
		end else begin
			job.len    = (is_letter || is_digit) ? enc_entry[8:6] : 3'd0;
			job.bits   = enc_entry[JOB_SYMS-1:0];
			job.a_en   = (c == CH_SPACE);
			job.a_char = CH_SLASH;
			job.b_en   = !in_data.end_of_text;
		end
	end

	assign job_push = accept && (job.len != 3'd0 || job.a_en || job.b_en);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q      <= 1'b0;
			sym_bits_q <= '0;
			sym_cnt_q  <= '0;
			ovf_q      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				dir_q <= cfg_wr_data;
			end
			if (accept && dir_q) begin
				if (do_lookup) begin
					sym_bits_q <= '0;
					sym_cnt_q  <= '0;
					ovf_q      <= 1'b0;
				end else begin
					sym_bits_q <= g_bits;
					sym_cnt_q  <= g_cnt;
					ovf_q      <= g_ovf;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/mct_queue.sv =====
// ----------------------------------------------------------------------------
// Morse translator job queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "morse_code_translator_core_defines.svh"

module mct_queue import mct_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  mct_job_t push_data,
	output logic     full,
	input  logic     pop,
	output logic     pop_valid,
	output mct_job_t pop_data
);

	mct_job_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	`MCT_ASSERT(a_no_overfill, !(push && full), "job pushed into a full queue")
	`MCT_ASSERT(a_no_underrun, !(pop && !pop_valid), "job popped from an empty queue")
	`MCT_ASSERT(a_count_range, cnt_q != 2'd3, "queue count out of range")
	`MCT_ASSERT_NEXT(a_fill_step, push && !pop && cnt_q == 2'd0, cnt_q == 2'd1,
		"queue count did not follow a lone push")

endmodule

// ===== hw/rtl/mct_back.sv =====
// ----------------------------------------------------------------------------
// Morse translator back end
// Steps through one job at a time and drives the registered result channel.
// ----------------------------------------------------------------------------
module mct_back import mct_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     job_valid,
	input  mct_job_t job,
	output logic     job_pop,
	output logic     out_valid,
	input  logic     out_ready,
	output mct_out_t out_data
);

	typedef enum logic [1:0] {PH_SYM, PH_A, PH_B} phase_t;

	phase_t   ph_q;
	logic     busy_q;
	logic [2:0] pos_q;
	mct_job_t job_q;
	logic     out_valid_q;
	mct_out_t out_q;

	logic     slot_free, emit, job_last, take;
	phase_t   start_ph, next_ph;
	mct_out_t cur;

	always_comb begin
		cur      = '0;
		job_last = 1'b0;
		next_ph  = ph_q;
		unique case (ph_q)
			PH_SYM: begin
				cur.out_char = job_q.bits[pos_q] ? CH_DASH : CH_DOT;
				if (pos_q == job_q.len - 3'd1) begin
					job_last = !job_q.a_en && !job_q.b_en;
					next_ph  = job_q.a_en ? PH_A : PH_B;
				end
			end
			PH_A: begin
				cur.out_char = job_q.a_char;
				cur.bad_code = job_q.a_bad;
				job_last     = !job_q.b_en;
				next_ph      = PH_B;
			end
			PH_B: begin
				cur.out_char = CH_SPACE;
				job_last     = 1'b1;
			end
			default: begin
				job_last = 1'b1;
			end
		endcase
		cur.run_last = job_last;

		if (job.len != 3'd0) begin
			start_ph = PH_SYM;
		end else if (job.a_en) begin
			start_ph = PH_A;
		end else begin
			start_ph = PH_B;
		end
	end

	assign slot_free = !out_valid_q || out_ready;
	assign emit      = busy_q && slot_free;
	assign take      = job_valid && (!busy_q || (emit && job_last));
	assign job_pop   = take;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_SYM;
			busy_q      <= 1'b0;
			pos_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				job_q  <= job;
				busy_q <= 1'b1;
				ph_q   <= start_ph;
				pos_q  <= 3'd0;
			end else if (emit) begin
				if (job_last) begin
					busy_q <= 1'b0;
				end else begin
					ph_q  <= next_ph;
					pos_q <= pos_q + 3'd1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				out_q       <= cur;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/morse_code_translator_core.sv =====
// ----------------------------------------------------------------------------
// Morse code translator core
// Streaming ITU Morse encoder and decoder with a direction register.
// ----------------------------------------------------------------------------
// The core takes one text byte per transfer on the input channel and gives
// one output byte per transfer on the result channel. With direction at 0 a
// letter or digit becomes its dots and dashes, a space becomes a slash, and a
// separating space follows every byte but the last of the text. With
// direction at 1 dots and dashes gather until a space or the end of the text,
// which yields the decoded character, or a question mark with bad_code set
// when the code is unknown or too long; a slash yields a space. The result
// run_last marks the final output of each input byte. The result stepper in
// the back end gives one result per cycle while the result channel is not
// stalled, and a byte yields up to six results.
// A two-entry job queue and the registered result stage let the input keep
// flowing while results wait. The direction is written through cfg_wr_en and
// cfg_wr_data and should only change while the core is idle; a partly
// gathered code survives a change of direction.
// ----------------------------------------------------------------------------
module morse_code_translator_core import mct_pkg::*; #(
	parameter int MAX_SYMBOLS = 6
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_wr_en,
	input  logic     cfg_wr_data,
	input  logic     in_valid,
	output logic     in_ready,
	input  mct_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output mct_out_t out_data
);

	// Jobs between the front end and the queue, and the queue and back end.
	logic     job_push;
	mct_job_t push_job;
	logic     queue_full;
	logic     job_pop;
	logic     job_valid;
	mct_job_t pop_job;

	// The front end classifies each byte and updates the gathered code at the
	// moment of the transfer, so the decoding state never waits on output.
	mct_front #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.queue_full (queue_full),
		.job_push   (job_push),
		.job        (push_job)
	);

	mct_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_data(push_job),
		.full     (queue_full),
		.pop      (job_pop),
		.pop_valid(job_valid),
		.pop_data (pop_job)
	);

	// The back end emits one result per cycle whenever the output register
	// is free or being drained.
	mct_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job      (pop_job),
		.job_pop  (job_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

// ===== tb/morse_translation_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse translation checker
// Watches the text and result channels of the translator, works out the
// bytes each accepted text byte should produce, and compares every result.
// ----------------------------------------------------------------------------
module morse_translation_checker import mct_pkg::*; #(
	parameter int MAX_SYMBOLS = 6
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_wr_en,
	input  logic     cfg_wr_data,
	input  logic     in_valid,
	input  logic     in_ready,
	input  mct_in_t  in_data,
	input  logic     out_valid,
	input  logic     out_ready,
	input  mct_out_t out_data,
	output int       fail_count,
	output int       open_count
);

	// ITU codes for A to Z, then 0 to 9.
	string itu_codes [TABLE_SIZE] = '{
		".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
		".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
		"...", "-", "..-", "...-", ".--", "-..-", "-.--", "--..",
		"-----", ".----", "..---", "...--", "....-", ".....", "-....",
		"--...", "---..", "----."
	};

	// Length in bits 8..6, symbols in bits 5..0 with the first at bit 0.
	logic [8:0]             itu_table [TABLE_SIZE];
	mct_out_t               expected_chars [$];
	logic                   decoding;
	logic [MAX_SYMBOLS-1:0] gathered_bits;
	logic [2:0]             gathered_len;
	logic                   gathered_overflow;
	int                     mismatches = 0;

	initial begin
		string s;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			s = itu_codes[i];
			itu_table[i] = '0;
			itu_table[i][8:6] = 3'(s.len());
			for (int j = 0; j < s.len(); j++) begin
				if (s.getc(j) == "-") begin
					itu_table[i][j] = 1'b1;
				end
			end
		end
	end

	function automatic mct_out_t char_result(input logic [7:0] ch, input logic bad);
		return '{out_char: ch, run_last: 1'b0, bad_code: bad};
	endfunction

	// Works out the results of one text byte and updates the gathered code.
	function automatic void translate_byte(input mct_in_t item);
		mct_out_t   outs [$];
		logic [7:0] ch;
		int         idx;
		int         hit;
		ch = item.in_char;
		if (!decoding) begin
			if (ch >= CH_LC_A && ch <= CH_LC_Z) begin
				ch = ch - CASE_GAP;
			end
			idx = -1;
			if (ch >= CH_UC_A && ch <= CH_UC_Z) begin
				idx = int'(ch - CH_UC_A);
			end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
				idx = int'(ch - CH_ZERO) + LETTERS;
			end
			if (idx >= 0) begin
				for (int j = 0; j < int'(itu_table[idx][8:6]); j++) begin
					outs.push_back(char_result(itu_table[idx][j] ? CH_DASH : CH_DOT, 1'b0));
				end
			end else if (ch == CH_SPACE) begin
				outs.push_back(char_result(CH_SLASH, 1'b0));
			end
			if (!item.end_of_text) begin
				outs.push_back(char_result(CH_SPACE, 1'b0));
			end
		end else begin
			if (ch == CH_DOT || ch == CH_DASH) begin
				if (gathered_len < 3'(MAX_SYMBOLS)) begin
					if (ch == CH_DASH) begin
						gathered_bits[gathered_len] = 1'b1;
					end
					gathered_len = gathered_len + 3'd1;
				end else begin
					gathered_overflow = 1'b1;
				end
			end
			// A space or the end of the text resolves whatever has gathered.
			if ((ch == CH_SPACE || item.end_of_text) &&
			    (gathered_overflow || gathered_len != 0)) begin
				hit = -1;
				if (!gathered_overflow) begin
					for (int i = 0; i < TABLE_SIZE; i++) begin
						if (hit < 0 && itu_table[i][8:6] == gathered_len &&
						    itu_table[i][5:0] == 6'(gathered_bits)) begin
							hit = i;
						end
					end
				end
				if (hit < 0) begin
					outs.push_back(char_result(CH_QUEST, 1'b1));
				end else if (hit < LETTERS) begin
					outs.push_back(char_result(CH_UC_A + 8'(hit), 1'b0));
				end else begin
					outs.push_back(char_result(CH_ZERO + 8'(hit - LETTERS), 1'b0));
				end
				gathered_bits = '0;
				gathered_len = '0;
				gathered_overflow = 1'b0;
			end
			if (ch == CH_SLASH) begin
				outs.push_back(char_result(CH_SPACE, 1'b0));
			end
		end
		if (outs.size() > 0) begin
			outs[outs.size() - 1].run_last = 1'b1;
		end
		foreach (outs[k]) begin
			expected_chars.push_back(outs[k]);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mct_out_t want;
		if (!arst_n) begin
			expected_chars.delete();
			decoding = 1'b0;
			gathered_bits = '0;
			gathered_len = '0;
			gathered_overflow = 1'b0;
		end else begin
			if (cfg_wr_en) begin
				decoding = cfg_wr_data;
			end
			// A result never comes from the byte taken at the same edge.
			if (out_valid && out_ready) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: expected no result, got char %h last %b bad %b",
					         $time, out_data.out_char, out_data.run_last,
					         out_data.bad_code);
					mismatches++;
				end else begin
					want = expected_chars.pop_front();
					if (out_data.out_char !== want.out_char ||
					    out_data.run_last !== want.run_last ||
					    out_data.bad_code !== want.bad_code) begin
						$display("%0t: expected char %h last %b bad %b, got %h %b %b",
						         $time, want.out_char, want.run_last, want.bad_code,
						         out_data.out_char, out_data.run_last, out_data.bad_code);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready) begin
				translate_byte(in_data);
			end
		end
		fail_count <= mismatches;
		open_count <= expected_chars.size();
	end

endmodule

// ===== tb/tb_morse_code_translator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse code translator core testbench
// Drives directed and random text through both translation directions with
// random idling on both channels; a checker beside the core compares results.
// ----------------------------------------------------------------------------
module tb_morse_code_translator_core;
	import mct_pkg::*;

	localparam int MAX_SYMBOLS    = 6;
	// The core may still be busy on a byte that produces nothing; this many
	// quiet cycles cover its input stage, job queue and result stage.
	localparam int DRAIN_CYCLES   = 16;
	// Longest correct stretch without a transfer is a drain plus a register
	// write plus a stall; the limit is several times that.
	localparam int WATCHDOG_LIMIT = 200;
	localparam int RANDOM_ITEMS   = 460;
	localparam int PHASES         = 8;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     cfg_wr_en;
	logic     cfg_wr_data;
	logic     in_valid;
	logic     in_ready;
	mct_in_t  in_data;
	logic     out_valid;
	logic     out_ready = 1'b0;
	mct_out_t out_data;

	int       fail_count;
	int       open_count;
	int       sent_items = 0;
	int       quiet_cycles = 0;
	int       hold_left = 0;
	// When set, neither side idles.
	logic     no_idling = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	morse_code_translator_core #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	morse_translation_checker #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.fail_count (fail_count),
		.open_count (open_count)
	);

	// The result side stalls in random bursts. Each burst starts with a low
	// out_ready and then holds it low while hold_left counts down to zero.
	always @(negedge clk) begin
		if (no_idling) begin
			out_ready <= 1'b1;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
			hold_left <= $urandom_range(0, 3);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// The watchdog ends the run once nothing has been transferred on either
	// channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL morse_code_translator_core");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one text byte and returns at the edge where it is transferred.
	// Valid stays high afterward, so back-to-back bytes need only one new
	// assignment per falling edge; an idle burst drops it first.
	task automatic push_byte(input logic [7:0] ch, input logic last);
		int gap;
		gap = (!no_idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{in_char: ch, end_of_text: last};
		do @(posedge clk); while (!in_ready);
		sent_items++;
	endtask

	// Stops offering bytes and waits until every expected result has been
	// transferred, then lets the core settle on any byte that made none.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (open_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// The direction register may only change while the core is idle.
	task automatic set_direction(input logic decode);
		wait_drained();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= decode;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Random plain text for the encoder: mostly letters of either case,
	// digits and spaces, with arbitrary bytes mixed in, and the occasional
	// end of text.
	task automatic send_plain_text(input int quota);
		logic [7:0] ch;
		repeat (quota) begin
			case ($urandom_range(0, 7))
				0, 1: ch = CH_UC_A + 8'($urandom_range(0, LETTERS - 1));
				2: ch = CH_LC_A + 8'($urandom_range(0, LETTERS - 1));
				3: ch = CH_ZERO + 8'($urandom_range(0, 9));
				4: ch = CH_SPACE;
				default: ch = 8'($urandom_range(0, 255));
			endcase
			push_byte(ch, $urandom_range(0, 7) == 0);
		end
	endtask

	// Random Morse text for the decoder. Most codes are real table codes so
	// that lookups hit; some are random patterns up to one symbol past the
	// limit, which may end up unknown or overflowed. Codes are followed by a
	// letter space, a word break, or a slash, or the last symbol ends the text.
	task automatic send_morse_text(input int quota);
		int         stop_at;
		int         sym_len;
		logic [8:0] code;
		logic [6:0] pattern;
		logic       ends_text;
		stop_at = sent_items + quota;
		while (sent_items < stop_at) begin
			if ($urandom_range(0, 9) == 0) begin
				push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
			end
			if ($urandom_range(0, 4) == 0) begin
				sym_len = $urandom_range(1, MAX_SYMBOLS + 1);
				pattern = 7'($urandom);
			end else begin
				code = mct_code(6'($urandom_range(0, TABLE_SIZE - 1)));
				sym_len = int'(code[8:6]);
				pattern = {1'b0, code[5:0]};
			end
			ends_text = ($urandom_range(0, 5) == 0);
			for (int j = 0; j < sym_len; j++) begin
				push_byte(pattern[j] ? CH_DASH : CH_DOT, ends_text && j == sym_len - 1);
			end
			if (!ends_text) begin
				case ($urandom_range(0, 6))
					0: begin
						push_byte(CH_SPACE, 1'b0);
						push_byte(CH_SLASH, 1'b0);
						push_byte(CH_SPACE, 1'b0);
					end
					1: push_byte(CH_SLASH, 1'b1);
					2: begin
						// A slash in the middle keeps the code, which the
						// following space then resolves.
						push_byte(CH_SLASH, 1'b0);
						push_byte(CH_SPACE, 1'b0);
					end
					default: push_byte(CH_SPACE, 1'b0);
				endcase
			end
		end
	endtask

	initial begin
		logic decode_dir;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Encoding after reset: both ends of the alphabet with case folding,
		// both ends of the digits, a space, bytes that have no code, and a
		// final byte that produces nothing at all.
		push_byte(CH_UC_A, 1'b0);
		push_byte(CH_LC_Z, 1'b0);
		push_byte(CH_ZERO, 1'b0);
		push_byte(CH_NINE, 1'b0);
		push_byte(CH_SPACE, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b1);

		set_direction(1'b1);
		// A plain lookup, then a space with nothing gathered, and a slash.
		push_byte(CH_DOT, 1'b0);
		push_byte(CH_DASH, 1'b0);
		push_byte(CH_SPACE, 1'b0);
		push_byte(CH_SPACE, 1'b0);
		push_byte(CH_SLASH, 1'b0);
		// A code that is not in the table, resolved by the end of the text.
		push_byte(CH_DOT, 1'b0);
		push_byte(CH_DOT, 1'b0);
		push_byte(CH_DASH, 1'b0);
		push_byte(CH_DASH, 1'b1);
		// One symbol more than the code register holds.
		for (int k = 0; k <= MAX_SYMBOLS; k++) begin
			push_byte(CH_DOT, k == MAX_SYMBOLS);
		end
		// A final slash with a code gathered: the character comes first.
		push_byte(CH_DASH, 1'b0);
		push_byte(CH_SLASH, 1'b1);
		// A gathered code survives a trip through the encoder, and a
		// lower-case final byte is ignored apart from the lookup it causes.
		push_byte(CH_DOT, 1'b0);
		set_direction(1'b0);
		push_byte(CH_NINE, 1'b1);
		set_direction(1'b1);
		push_byte(CH_LC_A, 1'b1);

		// Random phases alternate direction; the last one runs without idling.
		decode_dir = 1'($urandom_range(0, 1));
		for (int phase = 0; phase < PHASES; phase++) begin
			set_direction(decode_dir);
			no_idling = (phase == PHASES - 1) || ($urandom_range(0, 3) == 0);
			if (decode_dir) begin
				send_morse_text(RANDOM_ITEMS / PHASES);
			end else begin
				send_plain_text(RANDOM_ITEMS / PHASES);
			end
			decode_dir = ~decode_dir;
		end

		wait_drained();
		if (fail_count == 0 && open_count == 0) begin
			$display("PASS morse_code_translator_core");
		end else begin
			$display("FAIL morse_code_translator_core");
		end
		$finish;
	end

endmodule
